/* sv/ffgs_pkg.sv */
// ----------------------------------------------------------------------------
// ffgs_pkg
// Shared types and constants for the forest fire grid step block.
// ----------------------------------------------------------------------------
package ffgs_pkg;

   // cell codes
   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_TREE  = 2'd1,
      ST_FIRE  = 2'd2
   } cell_state_type;

   // item kinds
   localparam logic MODE_CELL  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROW_THRESHOLD   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNITE_THRESHOLD = 2'd3;

   localparam int GRID_WIDTH_W = 9;
   localparam int GRID_HEIGHT_W = 11;
   localparam int THRESHOLD_W = 17;
   localparam int DRAW_W = 16;
   localparam int STATE_W = 2;
   localparam int ENTRY_W = 4;

   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST       = 9'd50;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST      = 11'd50;
   localparam logic [THRESHOLD_W-1:0]   GROW_THRESHOLD_RST   = 17'd655;
   localparam logic [THRESHOLD_W-1:0]   IGNITE_THRESHOLD_RST = 17'd66;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // which neighbors count for the cell being finished
   typedef struct packed {
      logic ul_row;      // cell above exists
      logic ul_col;      // cell to the left exists
      logic dr_row;      // cell below exists
      logic dr_col;      // cell to the right exists
      logic frame_last;
   } emit_flags_type;

endpackage

/* sv/ffgs_req_if.sv */
// ----------------------------------------------------------------------------
// ffgs_req_if
// Input channel: one old-grid cell or a flush per beat.
// ----------------------------------------------------------------------------
interface ffgs_req_if import ffgs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [STATE_W-1:0] cell_state;
   logic [DRAW_W-1:0]  grow_draw;
   logic [DRAW_W-1:0]  ignite_draw;

   modport source (output valid, mode, cell_state, grow_draw, ignite_draw, input ready);
   modport sink (input valid, mode, cell_state, grow_draw, ignite_draw, output ready);
endinterface

/* sv/ffgs_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffgs_rsp_if
// Result channel: one new-grid cell per beat.
// ----------------------------------------------------------------------------
interface ffgs_rsp_if import ffgs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] new_state;
   logic               frame_last;

   modport source (output valid, new_state, frame_last, input ready);
   modport sink (input valid, new_state, frame_last, output ready);
endinterface

/* sv/ffgs_ram.sv */
// ----------------------------------------------------------------------------
// ffgs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffgs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/ffgs_queue.sv */
// ----------------------------------------------------------------------------
// ffgs_queue
// Small FIFO of finish commands between the front and the back.
// ----------------------------------------------------------------------------
module ffgs_queue import ffgs_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* sv/ffgs_front.sv */
// ----------------------------------------------------------------------------
// ffgs_front
// Takes cells, writes classified entries to the ring store, tracks the
// oldest pending cell and queues a finish command when it is complete.
// ----------------------------------------------------------------------------
module ffgs_front import ffgs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 1024,
   parameter int ADDR_W     = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   ffgs_req_if.sink               req_ch,
   output logic                   st_wr_en,
   output logic [ADDR_W-1:0]      st_wr_addr,
   output logic [ENTRY_W-1:0]     st_wr_entry,
   output logic                   st_wr_fire,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output logic [ADDR_W-1:0]      cmd_own_addr,
   output logic [ADDR_W-1:0]      cmd_up_addr,
   output logic [ADDR_W-1:0]      cmd_left_addr,
   output logic [ADDR_W-1:0]      cmd_down_addr,
   output logic [ADDR_W-1:0]      cmd_right_addr,
   output emit_flags_type         cmd_flags
);
   localparam int WB = $clog2(MAX_WIDTH + 2);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [GRID_WIDTH_W-1:0]  width_ff;
   logic [GRID_HEIGHT_W-1:0] height_ff;
   logic [THRESHOLD_W-1:0]   grow_thr_ff;
   logic [THRESHOLD_W-1:0]   ign_thr_ff;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [WB-1:0]     pending_ff, pending_in;
   logic [CB-1:0]     out_col_ff, out_col_in;
   logic [RB-1:0]     out_row_ff, out_row_in;

   logic [WB-1:0]     eff_w;
   logic [HB-1:0]     eff_h;
   logic              accept, is_cell, last_row, last_col, ready_emit;
   logic [WB-1:0]     pend_now;
   logic [ADDR_W-1:0] head_now, own_addr;
   logic [31:0]       need;
   cell_state_type    old_state;
   logic              grown, spont;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= GRID_WIDTH_RST;
         height_ff   <= GRID_HEIGHT_RST;
         grow_thr_ff <= GROW_THRESHOLD_RST;
         ign_thr_ff  <= IGNITE_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:       width_ff    <= csr_wr_data[GRID_WIDTH_W-1:0];
            CSR_GRID_HEIGHT:      height_ff   <= csr_wr_data[GRID_HEIGHT_W-1:0];
            CSR_GROW_THRESHOLD:   grow_thr_ff <= csr_wr_data[THRESHOLD_W-1:0];
            CSR_IGNITE_THRESHOLD: ign_thr_ff  <= csr_wr_data[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WB'(MAX_WIDTH);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HB'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HB'(MAX_HEIGHT);
      end else begin
         eff_h = HB'(height_ff);
      end
   end

   // classify the incoming cell
   always_comb begin
      unique case (req_ch.cell_state)
         ST_TREE: old_state = ST_TREE;
         ST_FIRE: old_state = ST_FIRE;
         default: old_state = ST_EMPTY;
      endcase
      grown = (old_state == ST_TREE) ||
              (old_state == ST_EMPTY && {1'b0, req_ch.grow_draw} < grow_thr_ff);
      spont = grown && ({1'b0, req_ch.ignite_draw} < ign_thr_ff);
   end

   assign req_ch.ready = cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_cell      = req_ch.mode == MODE_CELL;

   always_comb begin
      pend_now = pending_ff + WB'(is_cell);
      head_now = head_ff + ADDR_W'(is_cell);
      last_row = 32'(out_row_ff) + 32'd1 >= 32'(eff_h);
      last_col = 32'(out_col_ff) + 32'd1 >= 32'(eff_w);
      need     = (32'(out_col_ff) < 32'(eff_w)) ? 32'(eff_w) - 32'(out_col_ff) : 32'd1;
      // oldest cell is complete once its lower neighbor is in, or the rest
      // of the last row is in
      ready_emit = (pend_now != '0) &&
                   ((32'(pend_now) >= 32'(eff_w) + 32'd1) ||
                    (last_row && 32'(pend_now) >= need));
      own_addr = head_now - ADDR_W'(pend_now);
   end

   assign st_wr_en    = accept && is_cell;
   assign st_wr_addr  = head_ff;
   assign st_wr_entry = {spont, grown, old_state};
   assign st_wr_fire  = old_state == ST_FIRE;

   assign cmd_valid            = accept && ready_emit;
   assign cmd_own_addr         = own_addr;
   assign cmd_up_addr          = own_addr - ADDR_W'(eff_w);
   assign cmd_left_addr        = own_addr - ADDR_W'(1);
   assign cmd_down_addr        = own_addr + ADDR_W'(eff_w);
   assign cmd_right_addr       = own_addr + ADDR_W'(1);
   assign cmd_flags.ul_row     = out_row_ff != '0;
   assign cmd_flags.ul_col     = out_col_ff != '0;
   assign cmd_flags.dr_row     = !last_row;
   assign cmd_flags.dr_col     = !last_col;
   assign cmd_flags.frame_last = last_row && last_col;

   always_comb begin
      head_in    = head_ff;
      pending_in = pending_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         head_in    = head_now;
         pending_in = ready_emit ? pend_now - WB'(1) : pend_now;
         if (ready_emit) begin
            if (last_col) begin
               out_col_in = '0;
               out_row_in = last_row ? '0 : out_row_ff + RB'(1);
            end else begin
               out_col_in = out_col_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         pending_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         head_ff    <= head_in;
         pending_ff <= pending_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end
endmodule

/* sv/ffgs_back.sv */
// ----------------------------------------------------------------------------
// ffgs_back
// Pops finish commands, collects the store reads and applies the update
// rule into the result register.
// ----------------------------------------------------------------------------
module ffgs_back import ffgs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   input  emit_flags_type     cmd_flags,
   input  logic [ENTRY_W-1:0] own_entry,
   input  logic               up_fire,
   input  logic               left_fire,
   input  logic               down_fire,
   input  logic               right_fire,
   ffgs_rsp_if.source         rsp_ch
);
   logic               s1_valid_ff, s1_valid_in;
   emit_flags_type     flags_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] new_state_ff;
   logic               frame_last_ff;

   logic               out_free, s1_adv;
   logic               ul, dr, grown, spont;
   logic [STATE_W-1:0] old_state, next_state;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign cmd_pop  = cmd_valid && (!s1_valid_ff || out_free);

   // store data lands in the cycle after the pop
   always_comb begin
      old_state = own_entry[1:0];
      grown     = own_entry[2];
      spont     = own_entry[3];
      ul = (flags_ff.ul_row && up_fire) || (flags_ff.ul_col && left_fire);
      dr = (flags_ff.dr_row && down_fire) || (flags_ff.dr_col && right_fire);
      priority if (spont || (ul && old_state == ST_TREE) || (dr && grown)) begin
         next_state = ST_FIRE;
      end else if (old_state == ST_FIRE) begin
         next_state = ST_EMPTY;
      end else if (grown) begin
         next_state = ST_TREE;
      end else begin
         next_state = ST_EMPTY;
      end
   end

   always_comb begin
      s1_valid_in  = cmd_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         flags_ff <= cmd_flags;
      end
      if (s1_adv) begin
         new_state_ff  <= next_state;
         frame_last_ff <= flags_ff.frame_last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.new_state  = new_state_ff;
   assign rsp_ch.frame_last = frame_last_ff;
endmodule

/* sv/forest_fire_grid_step.sv */
// ----------------------------------------------------------------------------
// forest_fire_grid_step
// One generation of a forest fire automaton over a raster stream of cells.
// ----------------------------------------------------------------------------
// Takes one cell (or flush) per clock while the command queue has room and
// returns at most one new cell per beat, one per clock sustained while the
// output is ready. A cell's result leaves once the cell below it has arrived
// (grid_width cells later), or, in the last row, once the rest of that row
// is in; flush beats drain the last row. The queue is written on the edge of
// the beat that completes a cell; then come the store read and the result
// register. The old cells sit in a ring of 2**ceil(log2(2*MAX_WIDTH + 12))
// entries spread over five RAM copies, one per read (cell, up, left, down,
// right); the command queue holds 4 entries, so output stalls that fill the
// queue back-pressure the input.
module forest_fire_grid_step import ffgs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   ffgs_req_if.sink               req_ch,
   ffgs_rsp_if.source             rsp_ch
);
   // ring must outlive the oldest neighbor by the in-flight writes
   localparam int STORE_DEPTH = 1 << $clog2(2 * MAX_WIDTH + 2 * QUEUE_DEPTH + 4);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FLAGS_W     = $bits(emit_flags_type);
   localparam int CMD_W       = 5 * ADDR_W + FLAGS_W;

   logic               st_wr_en, st_wr_fire;
   logic [ADDR_W-1:0]  st_wr_addr;
   logic [ENTRY_W-1:0] st_wr_entry;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   logic [ADDR_W-1:0]  f_own, f_up, f_left, f_down, f_right;
   emit_flags_type     f_flags, q_flags;
   logic [CMD_W-1:0]   push_data, pop_data;
   logic [ADDR_W-1:0]  q_own, q_up, q_left, q_down, q_right;

   logic [ENTRY_W-1:0] own_entry;
   logic [0:0]         up_fire, left_fire, down_fire, right_fire;

   ffgs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_ch         (req_ch),
      .st_wr_en       (st_wr_en),
      .st_wr_addr     (st_wr_addr),
      .st_wr_entry    (st_wr_entry),
      .st_wr_fire     (st_wr_fire),
      .cmd_valid      (push_valid),
      .cmd_ready      (push_ready),
      .cmd_own_addr   (f_own),
      .cmd_up_addr    (f_up),
      .cmd_left_addr  (f_left),
      .cmd_down_addr  (f_down),
      .cmd_right_addr (f_right),
      .cmd_flags      (f_flags)
   );

   assign push_data = {f_own, f_up, f_left, f_down, f_right, f_flags};

   ffgs_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {q_own, q_up, q_left, q_down, q_right, q_flags} = pop_data;

   ffgs_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram_own (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_entry),
      .rd_en   (pop_ready),
      .rd_addr (q_own),
      .rd_data (own_entry)
   );

   ffgs_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_ram_up (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_fire),
      .rd_en   (pop_ready),
      .rd_addr (q_up),
      .rd_data (up_fire)
   );

   ffgs_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_ram_left (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_fire),
      .rd_en   (pop_ready),
      .rd_addr (q_left),
      .rd_data (left_fire)
   );

   ffgs_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_ram_down (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_fire),
      .rd_en   (pop_ready),
      .rd_addr (q_down),
      .rd_data (down_fire)
   );

   ffgs_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_ram_right (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_fire),
      .rd_en   (pop_ready),
      .rd_addr (q_right),
      .rd_data (right_fire)
   );

   ffgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_pop    (pop_ready),
      .cmd_flags  (q_flags),
      .own_entry  (own_entry),
      .up_fire    (up_fire[0]),
      .left_fire  (left_fire[0]),
      .down_fire  (down_fire[0]),
      .right_fire (right_fire[0]),
      .rsp_ch     (rsp_ch)
   );
endmodule

/* verif/forest_fire_grid_step_tb.sv */
// ----------------------------------------------------------------------------
// forest_fire_grid_step_tb
// Self-checking bench for one forest fire generation over a cell stream.
// ----------------------------------------------------------------------------
// A directed table on a single-cell grid checks the growth, ignition and
// burnout rules with the results written out. Random grids of many shapes
// and thresholds follow, each ended by complete frames and flush beats. Every
// result beat is compared with a local model of the stencil and window.
// ----------------------------------------------------------------------------
module forest_fire_grid_step_tb;
   import ffgs_pkg::*;

   localparam int MAX_W        = 256;
   localparam int MAX_H        = 1024;
   localparam int RING_DEPTH   = 2 * MAX_W + 1;
   localparam int RANDOM_CELLS = 1150;
   localparam int SETTLE       = 12;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [STATE_W-1:0] STATE_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 14;

   typedef struct packed {
      cell_state_type new_state;
      logic           frame_last;
   } cell_result_type;

   typedef struct packed {
      logic               spont;
      logic               grown;
      logic [STATE_W-1:0] old;
   } ring_entry_type;

   typedef struct packed {
      logic               mode;
      logic [STATE_W-1:0] state;
      logic [DRAW_W-1:0]  grow_draw;
      logic [DRAW_W-1:0]  ignite_draw;
      cell_state_type     exp_state;
      logic               exp_last;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   ffgs_req_if req_bus ();
   ffgs_rsp_if rsp_bus ();

   forest_fire_grid_step #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   // model copy of the registers
   logic [GRID_WIDTH_W-1:0]  grid_width  = GRID_WIDTH_RST;
   logic [GRID_HEIGHT_W-1:0] grid_height = GRID_HEIGHT_RST;
   logic [THRESHOLD_W-1:0]   grow_thr    = GROW_THRESHOLD_RST;
   logic [THRESHOLD_W-1:0]   ignite_thr  = IGNITE_THRESHOLD_RST;

   // model copy of the cell window
   ring_entry_type cell_ring [RING_DEPTH];
   int unsigned ring_head     = 0;
   int unsigned pending_cells = 0;
   int unsigned out_col       = 0;
   int unsigned out_row       = 0;

   cell_result_type awaited_cells [$];
   bit           failed        = 1'b0;
   int unsigned  beats_sent    = 0;
   int unsigned  src_idle_pct  = 30;
   int unsigned  rsp_stall_pct = 87;
   int unsigned  cycle_count   = 0;

   // single-cell grid, both thresholds at one half
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_CELL,  ST_EMPTY,     16'h7FFF, 16'hFFFF, ST_TREE,  1'b1},
      '{MODE_CELL,  ST_EMPTY,     16'h8000, 16'h0000, ST_EMPTY, 1'b1},
      '{MODE_CELL,  ST_EMPTY,     16'h0000, 16'h7FFF, ST_FIRE,  1'b1},
      '{MODE_CELL,  ST_EMPTY,     16'hFFFF, 16'hFFFF, ST_EMPTY, 1'b1},
      '{MODE_CELL,  ST_TREE,      16'h0000, 16'h8000, ST_TREE,  1'b1},
      '{MODE_CELL,  ST_TREE,      16'hFFFF, 16'h7FFF, ST_FIRE,  1'b1},
      '{MODE_CELL,  ST_TREE,      16'hFFFF, 16'h0000, ST_FIRE,  1'b1},
      '{MODE_CELL,  ST_FIRE,      16'h0000, 16'h0000, ST_EMPTY, 1'b1},
      '{MODE_CELL,  ST_FIRE,      16'hFFFF, 16'hFFFF, ST_EMPTY, 1'b1},
      '{MODE_CELL,  STATE_UNUSED, 16'h0000, 16'hFFFF, ST_TREE,  1'b1},
      '{MODE_CELL,  STATE_UNUSED, 16'hFFFF, 16'h0000, ST_EMPTY, 1'b1},
      '{MODE_FLUSH, ST_FIRE,      16'h0000, 16'h0000, ST_EMPTY, 1'b0},
      '{MODE_CELL,  STATE_UNUSED, 16'h7FFF, 16'h7FFF, ST_FIRE,  1'b1},
      '{MODE_FLUSH, STATE_UNUSED, 16'hFFFF, 16'hFFFF, ST_EMPTY, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (grid_width == 0) return 1;
      if (grid_width > MAX_W) return MAX_W;
      return grid_width;
   endfunction

   function automatic int unsigned eff_height();
      if (grid_height == 0) return 1;
      if (grid_height > MAX_H) return MAX_H;
      return grid_height;
   endfunction

   function automatic int unsigned ring_at(int unsigned base, int unsigned back,
                                           int unsigned fwd);
      return (base + RING_DEPTH - (back % RING_DEPTH) + (fwd % RING_DEPTH)) % RING_DEPTH;
   endfunction

   function automatic bit on_fire(int unsigned addr);
      return cell_ring[addr].old == ST_FIRE;
   endfunction

   // Takes one beat into the window; returns 1 when the oldest cell leaves.
   function automatic bit next_generation_cell(input logic mode,
                                               input logic [STATE_W-1:0] state,
                                               input logic [DRAW_W-1:0] gd,
                                               input logic [DRAW_W-1:0] id,
                                               output cell_result_type res);
      int unsigned w, h, a, need;
      logic [STATE_W-1:0] old;
      logic grown, ul, dr, last_row, last_col;
      ring_entry_type e;
      w = eff_width();
      h = eff_height();
      res = '{ST_EMPTY, 1'b0};
      if (mode == MODE_CELL) begin
         old = (state == STATE_UNUSED) ? ST_EMPTY : state;
         grown = (old == ST_TREE) || (old == ST_EMPTY && gd < grow_thr);
         cell_ring[ring_head] = '{grown && id < ignite_thr, grown, old};
         ring_head = (ring_head + 1) % RING_DEPTH;
         pending_cells++;
      end
      if (pending_cells == 0) return 1'b0;
      // not ready unless the cell below is in, or the last row is complete
      if (pending_cells < w + 1) begin
         if (out_row + 1 < h) return 1'b0;
         need = (out_col < w) ? w - out_col : 1;
         if (pending_cells < need) return 1'b0;
      end
      a = ring_at(ring_head, pending_cells, 0);
      e = cell_ring[a];
      last_row = (out_row + 1 >= h);
      last_col = (out_col + 1 >= w);
      ul = (out_row != 0 && on_fire(ring_at(a, w, 0))) ||
           (out_col != 0 && on_fire(ring_at(a, 1, 0)));
      dr = (!last_row && on_fire(ring_at(a, 0, w))) ||
           (!last_col && on_fire(ring_at(a, 0, 1)));
      if (e.spont || (ul && e.old == ST_TREE) || (dr && e.grown))
         res.new_state = ST_FIRE;
      else if (e.old == ST_FIRE)
         res.new_state = ST_EMPTY;
      else
         res.new_state = e.grown ? ST_TREE : ST_EMPTY;
      res.frame_last = last_row && last_col;
      pending_cells--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
      return 1'b1;
   endfunction

   function automatic logic [THRESHOLD_W-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 17'd65536;
         2: return '1;
         5: return THRESHOLD_W'($urandom_range(0, 3000));
         default: return THRESHOLD_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // mostly uniform, sometimes right at the threshold edge
   function automatic logic [DRAW_W-1:0] pick_draw(logic [THRESHOLD_W-1:0] thr);
      int unsigned d;
      if ($urandom_range(0, 9) < 2) begin
         d = thr - $urandom_range(0, 1);
         if (thr == 0) d = 0;
         if (d > 65535) d = 65535;
         return DRAW_W'(d);
      end
      return DRAW_W'($urandom_range(0, 65535));
   endfunction

   task automatic write_registers(logic [GRID_WIDTH_W-1:0] w, logic [GRID_HEIGHT_W-1:0] h,
                                  logic [THRESHOLD_W-1:0] g, logic [THRESHOLD_W-1:0] i);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_GRID_WIDTH;
      csr_wr_data <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index   <= CSR_GRID_HEIGHT;
      csr_wr_data <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index   <= CSR_GROW_THRESHOLD;
      csr_wr_data <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_index   <= CSR_IGNITE_THRESHOLD;
      csr_wr_data <= CSR_DATA_W'(i);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      grid_width  = w;
      grid_height = h;
      grow_thr    = g;
      ignite_thr  = i;
   endtask

   task automatic send_beat(logic mode, logic [STATE_W-1:0] state, logic [DRAW_W-1:0] gd,
                            logic [DRAW_W-1:0] id, bit typed, cell_result_type typed_res);
      cell_result_type res;
      if (beats_sent < 400) begin
         src_idle_pct  = 30;
         rsp_stall_pct = 87;
      end else if (beats_sent < 800) begin
         src_idle_pct  = 87;
         rsp_stall_pct = 30;
      end else begin
         src_idle_pct  = 0;
         rsp_stall_pct = 0;
      end
      if ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < src_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.cell_state  <= state;
      req_bus.grow_draw   <= gd;
      req_bus.ignite_draw <= id;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      if (next_generation_cell(mode, state, gd, id, res))
         awaited_cells.insert(awaited_cells.size(), typed ? typed_res : res);
   endtask

   task automatic send_cell();
      logic [STATE_W-1:0] st;
      int unsigned r;
      r = $urandom_range(0, 99);
      st = (r < 30) ? ST_EMPTY : (r < 72) ? ST_TREE : (r < 95) ? ST_FIRE : STATE_UNUSED;
      send_beat(MODE_CELL, st, pick_draw(grow_thr), pick_draw(ignite_thr), 1'b0, '0);
   endtask

   task automatic send_flush();
      send_beat(MODE_FLUSH, STATE_W'($urandom_range(0, 3)), DRAW_W'($urandom_range(0, 65535)),
                DRAW_W'($urandom_range(0, 65535)), 1'b0, '0);
   endtask

   // valid drops at the step of the last beat; then let the pipe empty
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (awaited_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Whole frames only, so no counter is left mid-frame at the next write.
   task automatic run_grid_phase(logic [GRID_WIDTH_W-1:0] w, logic [GRID_HEIGHT_W-1:0] h,
                                 logic [THRESHOLD_W-1:0] g, logic [THRESHOLD_W-1:0] i,
                                 int unsigned budget, output int unsigned sent);
      int unsigned frame_cells;
      write_registers(w, h, g, i);
      frame_cells = eff_width() * eff_height();
      sent = 0;
      do begin
         for (int c = 0; c < frame_cells; c++) begin
            if ($urandom_range(0, 99) < 3) send_flush();
            send_cell();
         end
         sent += frame_cells;
         // next frame may push out the last row without a flush
         if ($urandom_range(0, 1) == 1) repeat ($urandom_range(0, 2)) send_flush();
      end while (sent < budget);
      while (pending_cells != 0) send_flush();
      wait_idle();
   endtask

   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin : check_beat
      cell_result_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_cells.size() == 0) begin
            $error("new_state: expected none, got %0d", rsp_bus.new_state);
            failed = 1'b1;
         end else begin
            exp = awaited_cells.pop_front();
            if (rsp_bus.new_state !== exp.new_state) begin
               $error("new_state: expected %0d, got %0d", exp.new_state, rsp_bus.new_state);
               failed = 1'b1;
            end
            if (rsp_bus.frame_last !== exp.frame_last) begin
               $error("frame_last: expected %0d, got %0d", exp.frame_last, rsp_bus.frame_last);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned random_cells, phase_no, n, ew;
      logic [GRID_WIDTH_W-1:0] w;
      logic [GRID_HEIGHT_W-1:0] h;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_GRID_WIDTH;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_CELL;
      req_bus.cell_state  = ST_EMPTY;
      req_bus.grow_draw   = '0;
      req_bus.ignite_draw = '0;
      rsp_bus.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero width and height act as a one-cell grid
      write_registers('0, '0, 17'h08000, 17'h08000);
      foreach (directed_rows[k])
         send_beat(directed_rows[k].mode, directed_rows[k].state, directed_rows[k].grow_draw,
                   directed_rows[k].ignite_draw, 1'b1,
                   '{directed_rows[k].exp_state, directed_rows[k].exp_last});
      wait_idle();

      random_cells = 0;
      phase_no = 0;
      while (random_cells < RANDOM_CELLS) begin
         case (phase_no)
            2: begin
               run_grid_phase('1, 11'd2, '1, THRESHOLD_W'($urandom_range(0, 4000)), 1, n);
               random_cells += n;
            end
            4: begin
               run_grid_phase(9'd7, 11'd5, '0, 17'd65536, 1, n);
               random_cells += n;
            end
            default: begin
               case ($urandom_range(0, 19))
                  0:       w = '0;
                  1, 2, 3: w = GRID_WIDTH_W'($urandom_range(9, 24));
                  default: w = GRID_WIDTH_W'($urandom_range(1, 8));
               endcase
               case ($urandom_range(0, 19))
                  0:       h = '0;
                  1, 2, 3: h = GRID_HEIGHT_W'($urandom_range(6, 12));
                  default: h = GRID_HEIGHT_W'($urandom_range(1, 5));
               endcase
               ew = (w == 0) ? 1 : w;
               // keep wide grids short
               if (ew > 12 && h > 5) h = 11'd3;
               run_grid_phase(w, h, pick_threshold(), pick_threshold(),
                              $urandom_range(30, 90), n);
               random_cells += n;
            end
         endcase
         phase_no++;
      end

      wait_idle();
      if (failed)
         $display("tb: failure");
      else
         $display("tb: success");
      $finish;
   end

endmodule
